// File: src/pes_pkg.sv
package pes_pkg;

  localparam int unsigned MaxSources = 64;
  localparam int unsigned IdxW = $clog2(MaxSources);
  localparam int unsigned CntW = $clog2(MaxSources + 1);

  typedef enum logic [1:0] {
    MODE_CLEAR    = 2'd0,
    MODE_REGISTER = 2'd1,
    MODE_NEXT     = 2'd2,
    MODE_UNUSED   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_NONE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE,
    ST_OUT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic     take_in;
    logic     clear_cnt;
    logic     append;
    logic     scan_start;
    logic     scan_step;
    logic     scan_last;
    logic     update;
    logic     res_zero;
    logic     res_best;
    logic     out_load;
    status_e  status;
  } pes_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  empty;
    logic  scan_done;
  } pes_sts_t;

endpackage

// File: src/periodic_event_scheduler.sv
// Channel | handshake               | payload
// input   | in_valid / in_ready     | mode_i, source_id_i, period_i
// output  | out_valid / out_ready   | event_id_o, event_time_o, status_o
//
// Clear, register and unused items are decoded in ST_OUT to a result.
// Next items scan the table one entry per cycle through the single read
// port of the table memory, then write back the chosen entry in ST_UPDATE.
// rst_ni clears the entry count and control; the table itself is not cleared.
// A new item is taken once the previous result has gone or is leaving.
module periodic_event_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode_i,
  input  logic [31:0] source_id_i,
  input  logic [31:0] period_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] event_id_o,
  output logic [63:0] event_time_o,
  output logic [1:0]  status_o
);
  import pes_pkg::*;

  pes_cmd_t cmd;
  pes_sts_t sts;

  pes_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pes_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (mode_i),
    .source_id_i  (source_id_i),
    .period_i     (period_i),
    .event_id_o   (event_id_o),
    .event_time_o (event_time_o),
    .status_o     (status_o)
  );

endmodule

// File: src/pes_datapath.sv
module pes_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pes_pkg::pes_cmd_t cmd_i,
  output pes_pkg::pes_sts_t sts_o,
  input  logic [1:0]        mode_i,
  input  logic [31:0]       source_id_i,
  input  logic [31:0]       period_i,
  output logic [31:0]       event_id_o,
  output logic [63:0]       event_time_o,
  output logic [1:0]        status_o
);
  import pes_pkg::*;

  // Table memory, one write port and one registered read port
  logic [31:0] id_mem  [MaxSources];
  logic [31:0] per_mem [MaxSources];
  logic [63:0] due_mem [MaxSources];

  logic [1:0]      mode_q;
  logic [31:0]     sid_q, per_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] rd_cnt_q;
  logic [31:0]     rd_id_q, rd_per_q;
  logic [63:0]     rd_due_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            rd_vld_q;
  logic [31:0]     best_id_q, best_per_q;
  logic [63:0]     best_due_q;
  logic [IdxW-1:0] best_idx_q;
  logic            best_vld_q;
  logic [64:0]     sum;
  logic            better;

  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [31:0]     wr_id, wr_per;
  logic [63:0]     wr_due;

  // Input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      mode_q <= mode_i;
      sid_q  <= source_id_i;
      per_q  <= period_i;
    end
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clear_cnt) begin
      cnt_q <= '0;
    end else if (cmd_i.append) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  // Write port mux
  always_comb begin
    wr_en  = cmd_i.append | cmd_i.update;
    wr_idx = cmd_i.append ? cnt_q[IdxW-1:0] : best_idx_q;
    wr_id  = cmd_i.append ? sid_q : best_id_q;
    wr_per = cmd_i.append ? per_q : best_per_q;
    sum    = {1'b0, best_due_q} + {33'd0, best_per_q};
    wr_due = cmd_i.append ? {32'd0, per_q} : (sum[64] ? '1 : sum[63:0]);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      id_mem[wr_idx]  <= wr_id;
      per_mem[wr_idx] <= wr_per;
      due_mem[wr_idx] <= wr_due;
    end
  end

  // Scan read, one entry per cycle; rd_cnt_q counts the addresses issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_start | cmd_i.scan_step;
      if (cmd_i.scan_start) begin
        rd_cnt_q <= CntW'(1);
      end else if (cmd_i.scan_step) begin
        rd_cnt_q <= rd_cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start | cmd_i.scan_step) begin
      rd_id_q  <= id_mem[cmd_i.scan_start ? '0 : rd_cnt_q[IdxW-1:0]];
      rd_per_q <= per_mem[cmd_i.scan_start ? '0 : rd_cnt_q[IdxW-1:0]];
      rd_due_q <= due_mem[cmd_i.scan_start ? '0 : rd_cnt_q[IdxW-1:0]];
      rd_idx_q <= cmd_i.scan_start ? '0 : rd_cnt_q[IdxW-1:0];
    end
  end

  // Strict compare keeps the earlier entry on a full tie
  assign better = !best_vld_q || (rd_due_q < best_due_q) ||
                  ((rd_due_q == best_due_q) && (rd_id_q < best_id_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      best_vld_q <= 1'b0;
    end else if (rd_vld_q && better) begin
      best_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && better && !cmd_i.scan_start) begin
      best_id_q  <= rd_id_q;
      best_per_q <= rd_per_q;
      best_due_q <= rd_due_q;
      best_idx_q <= rd_idx_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o     <= cmd_i.status;
      event_id_o   <= cmd_i.res_best ? best_id_q : '0;
      event_time_o <= cmd_i.res_best ? best_due_q : '0;
    end
  end

  assign sts_o.mode      = mode_e'(mode_q);
  assign sts_o.full      = (cnt_q >= CntW'(MaxSources));
  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.scan_done = (rd_cnt_q >= cnt_q);

  // res_zero is implied when res_best is low; checked here
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (cmd_i.res_zero != cmd_i.res_best))
    else $error("result source select inconsistent");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> best_vld_q)
    else $error("update without a chosen entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> !sts_o.full)
    else $error("append into full table");

endmodule

// File: src/pes_ctrl.sv
module pes_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pes_pkg::pes_sts_t sts_i,
  output pes_pkg::pes_cmd_t cmd_o
);
  import pes_pkg::*;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   ovld_q;
  logic   fin;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid && in_ready) state_d = ST_OUT;
      ST_OUT:    begin
        if (busy_q && sts_i.mode == MODE_NEXT && !sts_i.empty) state_d = ST_SCAN;
        else state_d = ST_IDLE;
      end
      ST_SCAN:   if (sts_i.scan_done) state_d = ST_LAST;
      ST_LAST:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs; ST_OUT decodes the captured item
  always_comb begin
    cmd_o = '0;
    cmd_o.status = STATUS_OK;
    fin   = 1'b0;
    unique case (state_q)
      ST_IDLE: cmd_o.take_in = in_valid && in_ready;
      ST_OUT: begin
        unique case (sts_i.mode)
          MODE_CLEAR: begin
            cmd_o.clear_cnt = 1'b1;
            fin = 1'b1;
          end
          MODE_REGISTER: begin
            cmd_o.append = !sts_i.full;
            cmd_o.status = sts_i.full ? STATUS_FULL : STATUS_OK;
            fin = 1'b1;
          end
          MODE_NEXT: begin
            if (sts_i.empty) begin
              cmd_o.status = STATUS_EMPTY;
              fin = 1'b1;
            end else begin
              cmd_o.scan_start = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
        cmd_o.res_zero = fin;
        cmd_o.out_load = fin;
      end
      ST_SCAN: cmd_o.scan_step = !sts_i.scan_done;
      ST_LAST: cmd_o.scan_last = 1'b1;
      ST_UPDATE: begin
        cmd_o.update   = 1'b1;
        cmd_o.res_best = 1'b1;
        cmd_o.out_load = 1'b1;
        fin = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy_d = (state_q == ST_IDLE) ? (in_valid && in_ready) : 1'b0;

  // Result held until taken; next item waits for the output slot
  assign in_ready  = (state_q == ST_IDLE) && !(ovld_q && !out_ready);
  assign out_valid = ovld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      if (cmd_o.out_load) ovld_q <= 1'b1;
      else if (out_ready) ovld_q <= 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!ovld_q || out_ready))
    else $error("result overwritten before transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |=> (state_q == ST_IDLE))
    else $error("update not followed by idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> (state_q == ST_OUT))
    else $error("accepted item not decoded");

endmodule
